>>> rtl/core/slcg_pkg.sv
// Shared types and constants for the slime chunk LCG test core.
// No dependencies; used by every module in rtl/core.
package slcg_pkg;

  localparam logic [1:0] REG_MAP_SEED   = 2'd0;
  localparam logic [1:0] REG_ORIGIN_X   = 2'd1;
  localparam logic [1:0] REG_ORIGIN_Z   = 2'd2;

  localparam logic [31:0] HASH_XX_MUL = 32'h004c1906;
  localparam logic [31:0] HASH_X_MUL  = 32'h005ac0db;
  localparam logic [22:0] HASH_ZZ_MUL = 23'h4307a7;
  localparam logic [31:0] HASH_Z_MUL  = 32'h0005f24f;
  localparam logic [47:0] HASH_XOR    = 48'h00003ad8025f;

  localparam logic [47:0] LCG_MULT    = 48'h0005DEECE66D;
  localparam logic [31:0] LCG_MULT_LO = 32'hDEECE66D;
  localparam logic [15:0] LCG_MULT_HI = 16'h0005;
  localparam logic [47:0] LCG_ADD     = 48'h00000000000B;
  localparam int          DRAW_SHIFT  = 48 - 31;

  localparam logic [30:0] REJECT_MIN  = 31'h7FFFFFF8;
  localparam logic [31:0] RECIP_TEN   = 32'hCCCCCCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [63:0] map_seed;
    logic [31:0] origin_x;
    logic [31:0] origin_z;
  } cfg_t;

  typedef struct packed {
    logic [47:0] lcg_seed;
    logic [31:0] echo_x;
    logic [31:0] echo_z;
  } item_t;

endpackage

>>> rtl/core/slcg_front.sv
// Front pipeline: accepts offsets, adds origin, hashes with the world seed
// and forms the initial LCG state. Depends on slcg_pkg.
module slcg_front (
  input  logic              clk,
  input  logic              rst,
  input  slcg_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_x,
  input  logic [31:0]       in_z,
  output logic              out_valid,
  input  logic              out_ready,
  output slcg_pkg::item_t   out_item
);

  logic [5:1]  v;
  logic        en;
  logic [31:0] ex [1:5];
  logic [31:0] ez [1:5];
  logic [31:0] ax, az;
  logic [31:0] axx, ax5, azz, az5_2;
  logic [31:0] t1, ax5_3, az5_3;
  logic signed [55:0] t3;
  logic [47:0] sum_a, sum_b;
  logic [47:0] seed0;

  assign en        = !(v[5] && !out_ready);
  assign in_ready  = en;
  assign out_valid = v[5];
  assign out_item  = '{lcg_seed: seed0, echo_x: ex[5], echo_z: ez[5]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex[1] <= in_x;
      ez[1] <= in_z;
      ax    <= in_x + cfg.origin_x;
      az    <= in_z + cfg.origin_z;

      ex[2] <= ex[1];
      ez[2] <= ez[1];
      axx   <= ax * ax;
      ax5   <= ax * slcg_pkg::HASH_X_MUL;
      azz   <= az * az;
      az5_2 <= az * slcg_pkg::HASH_Z_MUL;

      ex[3] <= ex[2];
      ez[3] <= ez[2];
      t1    <= axx * slcg_pkg::HASH_XX_MUL;
      t3    <= $signed(azz) * $signed({1'b0, slcg_pkg::HASH_ZZ_MUL});
      ax5_3 <= ax5;
      az5_3 <= az5_2;

      ex[4] <= ex[3];
      ez[4] <= ez[3];
      sum_a <= cfg.map_seed[47:0] + {{16{t1[31]}}, t1} + {{16{ax5_3[31]}}, ax5_3};
      sum_b <= t3[47:0] + {{16{az5_3[31]}}, az5_3};

      ex[5] <= ex[4];
      ez[5] <= ez[4];
      seed0 <= (sum_a + sum_b) ^ slcg_pkg::HASH_XOR ^ slcg_pkg::LCG_MULT;
    end
  end

endmodule

>>> rtl/core/slcg_fifo.sv
// Short queue between the hash front and the draw back end.
// Depends on slcg_pkg for depth and item type.
module slcg_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  slcg_pkg::item_t   push_item,
  input  logic              pop,
  output slcg_pkg::item_t   pop_item,
  output logic              full,
  output logic              empty
);

  slcg_pkg::item_t            mem [slcg_pkg::FIFO_DEPTH];
  logic [slcg_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [slcg_pkg::FIFO_AW:0]   count;
  logic                         do_push, do_pop;

  assign full     = (count == (slcg_pkg::FIFO_AW+1)'(slcg_pkg::FIFO_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

endmodule

>>> rtl/core/slcg_back.sv
// Draw sequencer: steps the 48-bit LCG, reduces the draw modulo ten with
// rejection, and holds the result in the output register. Depends on slcg_pkg.
module slcg_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  slcg_pkg::item_t   q_item,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [71:0]       res_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;

  logic [2:0]  state, state_next;
  logic [47:0] lcg;
  logic [63:0] p_lo;
  logic [15:0] p_cross;
  logic [62:0] recip_prod;
  logic [31:0] ex, ez;
  logic [30:0] draw;
  logic [27:0] quot;
  logic [30:0] quot_ten;
  logic        reject, deliver;

  assign draw     = lcg[47:slcg_pkg::DRAW_SHIFT];
  assign quot     = recip_prod[slcg_pkg::RECIP_SHIFT +: 28];
  assign quot_ten = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign reject   = (draw >= slcg_pkg::REJECT_MIN);
  assign deliver  = (state == ST_CHK) && !reject && (!res_valid || res_ready);
  assign q_pop    = (state == ST_IDLE) && !q_empty;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (!q_empty) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = ST_DIV;
      ST_DIV:  state_next = ST_CHK;
      ST_CHK: begin
        if (reject) state_next = ST_MUL;
        else if (deliver) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (deliver) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        lcg <= q_item.lcg_seed;
        ex  <= q_item.echo_x;
        ez  <= q_item.echo_z;
      end
      ST_MUL: begin
        p_lo    <= {32'b0, lcg[31:0]} * {32'b0, slcg_pkg::LCG_MULT_LO};
        p_cross <= lcg[47:32] * slcg_pkg::LCG_MULT_LO[15:0]
                 + lcg[15:0] * slcg_pkg::LCG_MULT_HI;
      end
      ST_ADD: lcg <= p_lo[47:0] + {p_cross, 32'b0} + slcg_pkg::LCG_ADD;
      ST_DIV: recip_prod <= {32'b0, draw} * {31'b0, slcg_pkg::RECIP_TEN};
      default: ;
    endcase
    if (deliver) res_data <= {7'b0, draw == quot_ten, ez, ex};
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE) && !q_empty)
    else $error("queue popped outside idle");
  a_pop_mul: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == ST_MUL))
    else $error("pop not followed by multiply step");
  a_redraw: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHK) && reject |=> (state == ST_MUL) && !$rose(res_valid))
    else $error("rejected draw not redrawn");
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_CHK)
    else $error("result raised outside check step");
`endif

endmodule

>>> rtl/core/slime_chunk_lcg_test_core.sv
// Slime chunk LCG test core: hash front, queue and draw sequencer.
// Path from input accept to m_tvalid: the accept edge loads front
// stage 1, then 4 more front stages, the queue write and 5 sequencer steps.
// The sequencer takes one item at a time and pops the next only after it
// delivers; a rejected draw repeats multiply, add, divide and check. Front
// and queue overlap it. Sync reset zeroes the config and empties the pipeline.
module slime_chunk_lcg_test_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // offset_x[31:0], offset_z[63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // echo_x[31:0], echo_z[63:32], is_slime[64], zero[71:65]
);

  slcg_pkg::cfg_t  cfg;
  slcg_pkg::item_t f_item, q_item;
  logic            f_valid, q_full, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        slcg_pkg::REG_MAP_SEED:   cfg.map_seed <= cfg_data;
        slcg_pkg::REG_ORIGIN_X:   cfg.origin_x <= cfg_data[31:0];
        slcg_pkg::REG_ORIGIN_Z:   cfg.origin_z <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  slcg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_x      (s_tdata[31:0]),
    .in_z      (s_tdata[63:32]),
    .out_valid (f_valid),
    .out_ready (!q_full),
    .out_item  (f_item)
  );

  slcg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_item (f_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  slcg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_data  (m_tdata)
  );

endmodule

>>> tb/slime_chunk_lcg_test_core_chk.sv
// Checker for the slime chunk LCG test core: mirrors the register writes, predicts
// the verdict of every accepted chunk request and compares it with the result stream.
// Depends on slcg_pkg for the register indexes.
module slime_chunk_lcg_test_core_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // offset_x[31:0], offset_z[63:32]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,   // echo_x[31:0], echo_z[63:32], is_slime[64], zero[71:65]
  output int          errors,
  output int          pending,
  output int          checked,
  output int          slime_seen,
  output int          redraws
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [47:0] RAND_MULT = 48'h0005DEECE66D;
  localparam logic [47:0] RAND_INC  = 48'h00000000000B;
  localparam logic [63:0] MIX_XOR   = 64'h000000003AD8025F;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] z;
    logic        slime;
  } verdict_t;

  verdict_t    verdict_q[$];
  logic [63:0] seed_reg;
  logic [31:0] org_x;
  logic [31:0] org_z;

  function automatic logic [63:0] widen(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [31:0] next_draw(inout logic [47:0] s);
    s = s * RAND_MULT + RAND_INC;
    return {1'b0, s[47:17]};
  endfunction

  function automatic logic slime_verdict(input logic [31:0] ox, input logic [31:0] oz,
                                         output int redrew);
    logic [31:0] ax;
    logic [31:0] az;
    logic [31:0] u;
    logic [31:0] r;
    logic [31:0] t;
    logic [63:0] h;
    logic [47:0] s;
    ax = ox + org_x;
    az = oz + org_z;
    h = seed_reg + widen(ax * ax * 32'h004C1906) + widen(ax * 32'h005AC0DB)
        + widen(az * az) * 64'h00000000004307A7 + widen(az * 32'h0005F24F);
    h = h ^ MIX_XOR;
    s = h[47:0] ^ RAND_MULT;
    redrew = 0;
    u = next_draw(s);
    r = u % 32'd10;
    t = u - r + 32'd9;
    while (t[31]) begin
      redrew++;
      u = next_draw(s);
      r = u % 32'd10;
      t = u - r + 32'd9;
    end
    return r == 32'd0;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t want;
    verdict_t got;
    int       nred;
    if (rst) begin
      verdict_q.delete();
      seed_reg = '0;
      org_x    = '0;
      org_z    = '0;
      pending  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          slcg_pkg::REG_MAP_SEED: seed_reg = cfg_data;
          slcg_pkg::REG_ORIGIN_X: org_x    = cfg_data[31:0];
          slcg_pkg::REG_ORIGIN_Z: org_z    = cfg_data[31:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        want.x     = s_tdata[31:0];
        want.z     = s_tdata[63:32];
        want.slime = slime_verdict(want.x, want.z, nred);
        if (nred != 0) redraws++;
        verdict_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        checked++;
        if (m_tdata[64]) slime_seen++;
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t ns: result with no request waiting, expected none, got %h",
                   $time, m_tdata);
        end else begin
          got = verdict_q.pop_front();
          if (m_tdata[31:0] !== got.x) begin
            errors++;
            $display("%0t ns: echo_x expected %h got %h", $time, got.x, m_tdata[31:0]);
          end
          if (m_tdata[63:32] !== got.z) begin
            errors++;
            $display("%0t ns: echo_z expected %h got %h", $time, got.z, m_tdata[63:32]);
          end
          if (m_tdata[64] !== got.slime) begin
            errors++;
            $display("%0t ns: is_slime expected %b got %b (x %h z %h)",
                     $time, got.slime, m_tdata[64], got.x, got.z);
          end
          if (m_tdata[71:65] !== 7'd0) begin
            errors++;
            $display("%0t ns: padding expected 00 got %h", $time, m_tdata[71:65]);
          end
        end
      end
      pending = verdict_q.size();
    end
  end

endmodule

>>> tb/slime_chunk_lcg_test_core_test.sv
// Top of the slime chunk LCG test core bench: clock, reset, register settings and
// chunk request stimulus with random gaps on both streams, and the final verdict.
// Depends on slcg_pkg, the core and slime_chunk_lcg_test_core_chk.
module slime_chunk_lcg_test_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  REG_SPARE = 2'd3;
  localparam logic [47:0] LCG_A     = 48'h0005DEECE66D;
  localparam logic [47:0] LCG_C     = 48'h00000000000B;
  localparam logic [63:0] SEED_MIX  = 64'h000000003AD8025F;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = slcg_pkg::REG_MAP_SEED;
  logic [63:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic [63:0] s_tdata   = '0;
  logic        m_tready  = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [71:0] m_tdata;

  int          errors;
  int          pending;
  int          checked;
  int          slime_seen;
  int          redraws;
  int          requests  = 0;
  int          settings  = 0;
  int          hold_left = 0;
  bit          steady    = 1'b0;
  logic [31:0] cur_ox    = '0;
  logic [31:0] cur_oz    = '0;

  always #6 clk = ~clk;

  slime_chunk_lcg_test_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  slime_chunk_lcg_test_core_chk u_chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .slime_seen(slime_seen),
    .redraws   (redraws)
  );

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_seed();
    case ($urandom_range(0, 6))
      0:       return 64'h8000_0000_0000_0000;
      1:       return 64'h7FFF_FFFF_FFFF_FFFF;
      2:       return 64'hFFFF_FFFF_FFFF_FFFF;
      3:       return 64'h0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] pick_offset(input logic [31:0] org);
    logic [31:0] near;
    near = $urandom_range(0, 128);
    near = near - 32'd64;
    case ($urandom_range(0, 9))
      5, 6:    return near;
      7:       return pick_word();
      8:       return near - org;
      9:       return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // seed that puts the first draw for the absolute chunk (0, 0) at the given value
  function automatic logic [63:0] seed_for_draw(input logic [30:0] draw);
    logic [47:0] inv;
    logic [47:0] s1;
    logic [47:0] s0;
    inv = LCG_A;
    repeat (5) inv = inv * (48'd2 - LCG_A * inv);
    s1 = {draw, 17'($urandom)};
    s0 = (s1 - LCG_C) * inv;
    return {16'($urandom), s0 ^ LCG_A} ^ SEED_MIX;
  endfunction

  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      m_tready  <= 1'b0;
      hold_left <= pick_gap();
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_offsets(input logic [31:0] x, input logic [31:0] z);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, x};
    do @(posedge clk); while (!s_tready);
    requests++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] seed, input logic [31:0] ox,
                           input logic [31:0] oz, input bit spare);
    set_reg(slcg_pkg::REG_MAP_SEED, seed);
    set_reg(slcg_pkg::REG_ORIGIN_X, {$urandom, ox});
    set_reg(slcg_pkg::REG_ORIGIN_Z, {$urandom, oz});
    if (spare) set_reg(REG_SPARE, {$urandom, $urandom});
    cfg_we <= 1'b0;
    cur_ox = ox;
    cur_oz = oz;
    settings++;
  endtask

  task automatic forced_draw(input logic [30:0] draw, input logic [31:0] ox,
                             input logic [31:0] oz);
    drain();
    configure(seed_for_draw(draw), ox, oz, 1'b0);
    send_offsets(-ox, -oz);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    settings = 1;

    send_offsets(32'h0000_0000, 32'h0000_0000);
    send_offsets(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_offsets(32'h8000_0000, 32'h8000_0000);
    send_offsets(32'h7FFF_FFFF, 32'h8000_0000);
    send_offsets(32'h8000_0000, 32'h7FFF_FFFF);
    send_offsets(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_offsets(32'h0000_0001, 32'h0000_0001);
    send_offsets(32'h0000_0005, 32'hFFFF_FFFB);

    // coordinate wrap, plus a write to an unused index that must change nothing
    drain();
    configure(64'h8000_0000_0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_offsets(32'h0000_0001, 32'hFFFF_FFFF);
    send_offsets(32'h7FFF_FFFF, 32'h8000_0000);
    send_offsets(32'h8000_0001, 32'h7FFF_FFFF);

    // draws at and around the rejection threshold
    forced_draw(31'h7FFF_FFF8, 32'h0000_0000, 32'h0000_0000);
    forced_draw(31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    forced_draw(31'h7FFF_FFF7, 32'h0000_0000, 32'h0000_0000);
    forced_draw(31'h7FFF_FFEE, 32'h0000_3039, 32'hFFFF_FC19);
    forced_draw(31'h7FFF_FFFD, 32'hFFFF_FFFF, 32'h0000_0001);

    repeat (10) begin
      drain();
      configure(pick_seed(), pick_word(), pick_word(), $urandom_range(0, 3) == 0);
      repeat (130) begin
        if ($urandom_range(0, 39) == 0) steady = !steady;
        send_offsets(pick_offset(cur_ox), pick_offset(cur_oz));
      end
    end

    steady = 1'b0;
    drain();
    repeat (20) @(posedge clk);

    $display("Covered %0d chunk requests under %0d register settings.", requests, settings);
    $display("Checked %0d verdicts: %0d slime chunks, %0d needing a redraw.",
             checked, slime_seen, redraws);
    if (errors == 0 && pending == 0) begin
      $display("** slime_chunk_lcg_test_core: PASSED **");
    end else begin
      $display("** slime_chunk_lcg_test_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d verdicts outstanding.", pending);
    $display("** slime_chunk_lcg_test_core: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/slcg_pkg.sv
rtl/core/slcg_front.sv
rtl/core/slcg_fifo.sv
rtl/core/slcg_back.sv
rtl/core/slime_chunk_lcg_test_core.sv
tb/slime_chunk_lcg_test_core_chk.sv
tb/slime_chunk_lcg_test_core_test.sv
